@@ rtl/core/uet_pkg.sv @@
// Package for the ultrasonic echo timer: field widths, register indexes,
// status codes and register reset values. No dependencies.
package uet_pkg;

    localparam int COUNT_WIDTH_DEF = 31;

    localparam int TIMEOUT_W  = 31;
    localparam int TRIGGER_W  = 10;
    localparam int MIN_W      = 16;
    localparam int WIDTH_W    = 31;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LEVEL = 2'd3;

    localparam logic [STATUS_W-1:0] ST_VALID   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT = 2'd2;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 31'd30000;
    localparam logic [TRIGGER_W-1:0] TRIGGER_RST = 10'd50;
    localparam logic [MIN_W-1:0]     MIN_RST     = 16'd100;
    localparam logic                 IDLE_RST    = 1'b1;

    localparam logic [WIDTH_W-1:0] WIDTH_MAX = 31'h7FFF_FFFF;

endpackage

@@ rtl/core/uet_if.sv @@
// Channel interfaces of the ultrasonic echo timer: tick input, result output
// and configuration write. Depends on uet_pkg.
interface uet_in_if;
    logic valid;
    logic ready;
    logic start_req;
    logic echo_level;

    modport source (output valid, output start_req, output echo_level, input ready);
    modport sink (input valid, input start_req, input echo_level, output ready);
endinterface

interface uet_out_if;
    logic                          valid;
    logic                          ready;
    logic                          trigger_out;
    logic                          busy_res;
    logic                          done_res;
    logic [uet_pkg::STATUS_W-1:0]  status;
    logic [uet_pkg::WIDTH_W-1:0]   width;

    modport source (output valid, output trigger_out, output busy_res, output done_res,
                    output status, output width, input ready);
    modport sink (input valid, input trigger_out, input busy_res, input done_res,
                  input status, input width, output ready);
endinterface

interface uet_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [uet_pkg::CFG_IDX_W-1:0]  index;
    logic [uet_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/ultrasonic_echo_timer_unit.sv @@
// Top level of the ultrasonic echo timer: measurement sequencer and result
// register. Depends on uet_pkg and the channel interfaces in uet_if.
//
// Usage:
//   req : one transaction per microsecond tick, carrying start_req and the
//         sampled echo_level.
//   res : one transaction per tick: trigger level, busy, done, status and
//         echo width (or elapsed ticks on timeout) after that tick.
//   cfg : register writes (timeout, trigger length, minimum width, trigger
//         idle level); always ready, write only while idle.
// Timing: a tick's result is registered onto res in the cycle after its req
//   transaction. Throughput: one tick per cycle unless res stalls, set by
//   the counter step and compares between the state and result registers.
// Reset: registers take their default values, the sequencer returns to idle
//   and the result register is emptied.
// Stall: while res is stalled and the result register is full, req is not
//   ready; the held result stays unchanged until taken.
module ultrasonic_echo_timer_unit #(
    parameter int COUNT_WIDTH = uet_pkg::COUNT_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    uet_cfg_if.sink       cfg,
    uet_in_if.sink        req,
    uet_out_if.source     res
);

    localparam int CMP_W = 33;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    localparam logic [1:0] PH_IDLE      = 2'd0;
    localparam logic [1:0] PH_TRIGGER   = 2'd1;
    localparam logic [1:0] PH_WAIT_RISE = 2'd2;
    localparam logic [1:0] PH_WAIT_FALL = 2'd3;

    logic [uet_pkg::TIMEOUT_W-1:0] timeout_reg;
    logic [uet_pkg::TRIGGER_W-1:0] trigger_reg;
    logic [uet_pkg::MIN_W-1:0]     min_reg;
    logic                          idle_level_reg;

    logic [1:0]                    phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0]        elapsed_reg, elapsed_next;
    logic [uet_pkg::TRIGGER_W-1:0] pulse_reg, pulse_next;
    logic                          echo_prev_reg;

    logic                          out_valid_reg;
    logic                          trig_reg, trig_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [uet_pkg::STATUS_W-1:0]  status_reg, status_next;
    logic [uet_pkg::WIDTH_W-1:0]   width_reg, width_next;

    logic                          accept;
    logic                          rise, fall;
    logic [COUNT_WIDTH-1:0]        elapsed_inc;
    logic                          over_timeout;
    logic [uet_pkg::WIDTH_W-1:0]   width_sat;

    assign cfg.ready = 1'b1;
    assign req.ready = !out_valid_reg || res.ready;
    assign accept    = req.valid && req.ready;

    assign rise = req.echo_level && !echo_prev_reg;
    assign fall = !req.echo_level && echo_prev_reg;

    assign elapsed_inc  = (elapsed_reg != COUNT_MAX) ? elapsed_reg + COUNT_WIDTH'(1)
                                                     : elapsed_reg;
    assign over_timeout = CMP_W'(elapsed_inc) > CMP_W'(timeout_reg);
    assign width_sat    = (CMP_W'(elapsed_inc) > CMP_W'(uet_pkg::WIDTH_MAX))
                          ? uet_pkg::WIDTH_MAX
                          : uet_pkg::WIDTH_W'(CMP_W'(elapsed_inc));

    always_comb
    begin
        phase_next   = phase_reg;
        elapsed_next = elapsed_reg;
        pulse_next   = pulse_reg;
        trig_next    = idle_level_reg;
        done_next    = 1'b0;
        status_next  = uet_pkg::ST_VALID;
        width_next   = '0;
        if (phase_reg == PH_IDLE)
        begin
            if (req.start_req)
            begin
                phase_next   = PH_TRIGGER;
                elapsed_next = '0;
                pulse_next   = uet_pkg::TRIGGER_W'(1);
                trig_next    = !idle_level_reg;
            end
        end
        else
        begin
            elapsed_next = elapsed_inc;
            if (phase_reg == PH_TRIGGER)
            begin
                if (pulse_reg < trigger_reg)
                begin
                    pulse_next = pulse_reg + uet_pkg::TRIGGER_W'(1);
                    trig_next  = !idle_level_reg;
                end
                else
                begin
                    phase_next = PH_WAIT_RISE;
                end
            end
            case (phase_next)
                PH_WAIT_RISE:
                begin
                    if (rise)
                    begin
                        elapsed_next = '0;
                        phase_next   = PH_WAIT_FALL;
                    end
                    else if (over_timeout)
                    begin
                        done_next   = 1'b1;
                        status_next = uet_pkg::ST_TIMEOUT;
                        width_next  = width_sat;
                        phase_next  = PH_IDLE;
                    end
                end
                PH_WAIT_FALL:
                begin
                    if (fall)
                    begin
                        done_next   = 1'b1;
                        width_next  = width_sat;
                        status_next = (CMP_W'(elapsed_inc) < CMP_W'(min_reg))
                                      ? uet_pkg::ST_SHORT : uet_pkg::ST_VALID;
                        phase_next  = PH_IDLE;
                    end
                    else if (over_timeout)
                    begin
                        done_next   = 1'b1;
                        status_next = uet_pkg::ST_TIMEOUT;
                        width_next  = width_sat;
                        phase_next  = PH_IDLE;
                    end
                end
                default:
                begin
                end
            endcase
        end
        busy_next = (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg    <= uet_pkg::TIMEOUT_RST;
            trigger_reg    <= uet_pkg::TRIGGER_RST;
            min_reg        <= uet_pkg::MIN_RST;
            idle_level_reg <= uet_pkg::IDLE_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                uet_pkg::CFG_TIMEOUT:    timeout_reg    <= cfg.data[uet_pkg::TIMEOUT_W-1:0];
                uet_pkg::CFG_TRIGGER:    trigger_reg    <= cfg.data[uet_pkg::TRIGGER_W-1:0];
                uet_pkg::CFG_MIN_WIDTH:  min_reg        <= cfg.data[uet_pkg::MIN_W-1:0];
                uet_pkg::CFG_IDLE_LEVEL: idle_level_reg <= cfg.data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            elapsed_reg   <= '0;
            pulse_reg     <= '0;
            echo_prev_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg     <= phase_next;
                elapsed_reg   <= elapsed_next;
                pulse_reg     <= pulse_next;
                echo_prev_reg <= req.echo_level;
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            trig_reg   <= trig_next;
            busy_reg   <= busy_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            width_reg  <= width_next;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.trigger_out = trig_reg;
    assign res.busy_res    = busy_reg;
    assign res.done_res    = done_reg;
    assign res.status      = status_reg;
    assign res.width       = width_reg;

endmodule
